// ----- design/prfb_pkg.sv -----
// prfb_pkg: shared types, constants and the pattern table for the page framebuffer fill unit
// no dependencies; used by the front, queue, back and top modules (the checker does not use it)
package prfb_pkg;

  // default screen geometry
  localparam int unsigned SCREEN_COLUMNS_DEF = 128;
  localparam int unsigned SCREEN_PAGES_DEF   = 8;

  // field widths sized for the largest supported screen (256 columns, 16 pages)
  localparam int unsigned COL_W  = 8;
  localparam int unsigned PAGE_W = 4;

  // command queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic FUNC_FILL = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [7:0] FILL_TABLE [8][8] = '{
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
    '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA},
    '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00},
    '{8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55},
    '{8'h55, 8'h00, 8'h55, 8'h00, 8'h55, 8'h00, 8'h55, 8'h00},
    '{8'hFF, 8'hAA, 8'hFF, 8'hAA, 8'hFF, 8'hAA, 8'hFF, 8'hAA},
    '{8'h11, 8'h22, 8'h44, 8'h88, 8'h11, 8'h22, 8'h44, 8'h88},
    '{8'h88, 8'h44, 8'h22, 8'h11, 8'h88, 8'h44, 8'h22, 8'h11}
  };

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_FILL,
    B_DRAIN,
    B_READ,
    B_RESP
  } back_state_e;

  // classified item; for a read, col_lo/page_first carry the address and
  // active says the address is on screen
  typedef struct packed {
    logic              is_read;
    logic              active;
    logic [COL_W-1:0]  col_lo;
    logic [COL_W-1:0]  col_hi;
    logic [PAGE_W-1:0] page_first;
    logic [PAGE_W-1:0] page_last;
    logic [7:0]        top_mask;
    logic [7:0]        bot_mask;
    logic [2:0]        pattern;
  } cmd_t;

  function automatic logic [7:0] pattern_byte(input logic [2:0] sel, input logic [2:0] x);
    return FILL_TABLE[sel][x];
  endfunction

endpackage

// ----- design/prfb_front.sv -----
// prfb_front: accepts items, clips fill rectangles to the screen and builds queue commands
// depends on prfb_pkg
module prfb_front #(
  parameter int unsigned SCREEN_COLUMNS = prfb_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_PAGES   = prfb_pkg::SCREEN_PAGES_DEF
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic signed [8:0]  rect_left_i,
  input  logic signed [7:0]  rect_top_i,
  input  logic [7:0]         rect_width_i,
  input  logic [6:0]         rect_height_i,
  input  logic [2:0]         pattern_sel_i,
  input  logic [2:0]         read_page_i,
  input  logic [6:0]         read_column_i,
  input  logic               queue_full_i,
  input  logic               clearing_i,
  output logic               push_o,
  output prfb_pkg::cmd_t     cmd_o
);
  import prfb_pkg::*;

  localparam int unsigned ROWS = SCREEN_PAGES * 8;
  localparam logic signed [10:0] COL_MAX  = 11'(SCREEN_COLUMNS - 1);
  localparam logic signed [9:0]  ROW_MAX  = 10'(ROWS - 1);
  localparam logic [4:0]         PAGE_LIM = 5'(SCREEN_PAGES);
  localparam logic [8:0]         COL_LIM  = 9'(SCREEN_COLUMNS);

  logic signed [10:0] left_s, right_s, xl_c, xr_c;
  logic signed [9:0]  ytop_s, ybot_s, yt_c, yb_c;
  logic               fill_active, read_active;

  assign left_s  = 11'(rect_left_i);
  assign right_s = left_s + 11'(rect_width_i) - 11'sd1;
  assign ytop_s  = 10'(rect_top_i);
  assign ybot_s  = ytop_s + 10'(rect_height_i) - 10'sd1;

  assign xl_c = (left_s < 11'sd0) ? 11'sd0 : left_s;
  assign xr_c = (right_s > COL_MAX) ? COL_MAX : right_s;
  assign yt_c = (ytop_s < 10'sd0) ? 10'sd0 : ytop_s;
  assign yb_c = (ybot_s > ROW_MAX) ? ROW_MAX : ybot_s;

  // column range empty after clipping covers rectangles wholly off either side
  assign fill_active = (rect_width_i != 8'd0) && (rect_height_i != 7'd0) &&
                       (yt_c <= yb_c) && (xl_c <= xr_c);

  assign read_active = ({2'b00, read_page_i} < PAGE_LIM) &&
                       ({2'b00, read_column_i} < COL_LIM);

  always_comb begin
    cmd_o         = '0;
    cmd_o.is_read = (func_i == FUNC_READ);
    cmd_o.pattern = pattern_sel_i;
    if (func_i == FUNC_READ) begin
      cmd_o.active     = read_active;
      cmd_o.col_lo     = {1'b0, read_column_i};
      cmd_o.page_first = {1'b0, read_page_i};
    end else begin
      cmd_o.active     = fill_active;
      cmd_o.col_lo     = xl_c[COL_W-1:0];
      cmd_o.col_hi     = xr_c[COL_W-1:0];
      cmd_o.page_first = yt_c[6:3];
      cmd_o.page_last  = yb_c[6:3];
      cmd_o.top_mask   = 8'hFF << yt_c[2:0];
      cmd_o.bot_mask   = 8'hFF >> (3'd7 - yb_c[2:0]);
    end
  end

  // nothing is taken while the store is being cleared after reset
  assign in_stall_o = queue_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

endmodule

// ----- design/prfb_cmd_queue.sv -----
// prfb_cmd_queue: short command queue between the front and the back
// depends on prfb_pkg
module prfb_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  prfb_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output prfb_pkg::cmd_t cmd_o,
  output logic           full_o,
  output logic           empty_o
);
  import prfb_pkg::*;

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t          entries_q [QUEUE_DEPTH];
  logic [QW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QW:0]   count_q, count_d;

  assign full_o  = (count_q == (QW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entries_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop_i ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q + (QW+1)'(push_i) - (QW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/prfb_back.sv -----
// prfb_back: frame store, clearing pass and read-modify-write sequencer with result register
// depends on prfb_pkg
module prfb_back #(
  parameter int unsigned SCREEN_COLUMNS = prfb_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_PAGES   = prfb_pkg::SCREEN_PAGES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           queue_empty_i,
  input  prfb_pkg::cmd_t queue_cmd_i,
  output logic           queue_pop_o,
  output logic           clearing_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     read_data_o,
  output logic           was_read_o
);
  import prfb_pkg::*;

  localparam int unsigned DEPTH = SCREEN_PAGES * SCREEN_COLUMNS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [7:0] mem [DEPTH];

  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              wv_q, wv_d;
  logic [AW-1:0]     waddr_q, waddr_d;
  logic [7:0]        wbyte_q, wbyte_d;
  logic [7:0]        rdata_q;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        read_data_q, read_data_d;
  logic              was_read_q, was_read_d;

  logic              rd_en, we, load, slot_free, last_byte;
  logic [AW-1:0]     cur_addr, mem_waddr;
  logic [7:0]        mem_wdata, page_mask;

  assign cur_addr  = AW'(32'(page_q) * 32'(SCREEN_COLUMNS) + 32'(col_q));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign last_byte = (page_q == cmd_q.page_last) && (col_q == cmd_q.col_hi);
  assign clearing_o = (state_q == B_CLEAR);

  // partial top and bottom pages keep only the covered rows
  always_comb begin
    page_mask = 8'hFF;
    if (page_q == cmd_q.page_first) begin
      page_mask = page_mask & cmd_q.top_mask;
    end
    if (page_q == cmd_q.page_last) begin
      page_mask = page_mask & cmd_q.bot_mask;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (clr_q == LAST_ADDR) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!queue_empty_i) begin
          if (queue_cmd_i.is_read) begin
            state_d = B_READ;
          end else if (queue_cmd_i.active) begin
            state_d = B_FILL;
          end else begin
            state_d = B_RESP;
          end
        end
      end
      B_FILL: begin
        if (last_byte) begin
          state_d = B_DRAIN;
        end
      end
      B_DRAIN: state_d = B_RESP;
      B_READ:  state_d = B_RESP;
      B_RESP: begin
        if (slot_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    col_d       = col_q;
    page_d      = page_q;
    clr_d       = clr_q;
    wv_d        = 1'b0;
    waddr_d     = waddr_q;
    wbyte_d     = wbyte_q;
    rd_en       = 1'b0;
    queue_pop_o = 1'b0;
    load        = 1'b0;
    case (state_q)
      B_CLEAR: clr_d = clr_q + 1'b1;
      B_IDLE: begin
        if (!queue_empty_i) begin
          queue_pop_o = 1'b1;
          cmd_d       = queue_cmd_i;
          col_d       = queue_cmd_i.col_lo;
          page_d      = queue_cmd_i.page_first;
        end
      end
      B_FILL: begin
        // read this byte now, write it back next cycle
        rd_en   = 1'b1;
        wv_d    = 1'b1;
        waddr_d = cur_addr;
        wbyte_d = pattern_byte(cmd_q.pattern, col_q[2:0]) & page_mask;
        if (page_q == cmd_q.page_last) begin
          page_d = cmd_q.page_first;
          col_d  = col_q + 1'b1;
        end else begin
          page_d = page_q + 1'b1;
        end
      end
      B_DRAIN: ;
      B_READ:  rd_en = cmd_q.active;
      B_RESP:  load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    we        = clearing_o || wv_q;
    mem_waddr = clearing_o ? clr_q : waddr_q;
    mem_wdata = clearing_o ? 8'h00 : (rdata_q | wbyte_q);
  end

  always_comb begin
    out_valid_d = load || (out_valid_q && out_stall_i);
    read_data_d = read_data_q;
    was_read_d  = was_read_q;
    if (load) begin
      read_data_d = (cmd_q.is_read && cmd_q.active) ? rdata_q : 8'h00;
      was_read_d  = cmd_q.is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[cur_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wv_q        <= wv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    col_q       <= col_d;
    page_q      <= page_d;
    waddr_q     <= waddr_d;
    wbyte_q     <= wbyte_d;
    read_data_q <= read_data_d;
    was_read_q  <= was_read_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign was_read_o  = was_read_q;

endmodule

// ----- design/pattern_rect_fill_page_framebuffer_unit.sv -----
// Monochrome page framebuffer with 8x8 pattern rectangle fill. After reset the frame store is
// cleared one byte per cycle, all SCREEN_PAGES*SCREEN_COLUMNS bytes (1024 by default), with
// in_stall_o high throughout. Items are clipped and queued by the front end, so input is taken
// while the back end works. In the back end a read word passes the READ and RESP states; a fill
// walks its clipped columns x pages touched in FILL, one read-modify-write per cycle on the
// frame store (one read port, one write port), then DRAIN and RESP; a fill that draws nothing
// goes straight to RESP. The back end also waits while the result register holds a stalled
// word. Every item returns exactly one result word, in order.
module pattern_rect_fill_page_framebuffer_unit #(
  parameter int unsigned SCREEN_COLUMNS = prfb_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_PAGES   = prfb_pkg::SCREEN_PAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic signed [8:0] rect_left_i,
  input  logic signed [7:0] rect_top_i,
  input  logic [7:0]        rect_width_i,
  input  logic [6:0]        rect_height_i,
  input  logic [2:0]        pattern_sel_i,
  input  logic [2:0]        read_page_i,
  input  logic [6:0]        read_column_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o,
  output logic              was_read_o
);
  import prfb_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic push, pop, queue_full, queue_empty, clearing;

  prfb_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_PAGES  (SCREEN_PAGES)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .rect_left_i  (rect_left_i),
    .rect_top_i   (rect_top_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .pattern_sel_i(pattern_sel_i),
    .read_page_i  (read_page_i),
    .read_column_i(read_column_i),
    .queue_full_i (queue_full),
    .clearing_i   (clearing),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  prfb_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (queue_cmd),
    .full_o (queue_full),
    .empty_o(queue_empty)
  );

  prfb_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_PAGES  (SCREEN_PAGES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_empty_i(queue_empty),
    .queue_cmd_i  (queue_cmd),
    .queue_pop_o  (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .was_read_o   (was_read_o)
  );

endmodule

// ----- design/prfb_checker.sv -----
// prfb_checker: port-level assertions for the page framebuffer fill unit, bound to the top level
// depends on pattern_rect_fill_page_framebuffer_unit
module prfb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              func_i,
  input logic signed [8:0] rect_left_i,
  input logic signed [7:0] rect_top_i,
  input logic [7:0]        rect_width_i,
  input logic [6:0]        rect_height_i,
  input logic [2:0]        pattern_sel_i,
  input logic [2:0]        read_page_i,
  input logic [6:0]        read_column_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [7:0]        read_data_o,
  input logic              was_read_o
);

  logic       in_acc, out_acc;
  logic [3:0] pending_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // words taken in but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) && $stable(was_read_o))
    else $error("result word changed while stalled");

  a_fill_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_read_o |-> read_data_o == 8'h00)
    else $error("fill acknowledge carries non-zero data");

  a_clear_stall: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken before clearing pass");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("result word without an outstanding item");

endmodule

bind pattern_rect_fill_page_framebuffer_unit prfb_checker u_checker (.*);
